// File: src/rtsd_pkg.sv
package rtsd_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned NAME_BYTES_DEF = 10;

  // Fixed field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned NAME_HI_W = 16;
  localparam int unsigned NAME_LO_W = 64;
  localparam int unsigned NAME_W    = NAME_HI_W + NAME_LO_W;
  localparam int unsigned AGE_W     = 8;
  localparam int unsigned PHONE_W   = 50;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned COUNT_W   = 5;

  // Operations
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  // Key kinds
  localparam logic [KIND_W-1:0] KEY_NAME  = 2'd0;
  localparam logic [KIND_W-1:0] KEY_AGE   = 2'd1;
  localparam logic [KIND_W-1:0] KEY_PHONE = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [NAME_HI_W-1:0] name_upper;
    logic [NAME_LO_W-1:0] name_lower;
    logic [AGE_W-1:0]     age;
    logic [PHONE_W-1:0]   phone;
  } record_t;

  localparam int unsigned RECORD_W = $bits(record_t);

endpackage

// File: src/rtsd_if.sv
interface rtsd_req_if;
  logic                             valid;
  logic                             ready;
  logic [rtsd_pkg::OP_W-1:0]        operation;
  logic [rtsd_pkg::KIND_W-1:0]      key_kind;
  logic [rtsd_pkg::NAME_HI_W-1:0]   name_upper;
  logic [rtsd_pkg::NAME_LO_W-1:0]   name_lower;
  logic [rtsd_pkg::AGE_W-1:0]       age_value;
  logic [rtsd_pkg::PHONE_W-1:0]     phone_value;

  modport source (
    output valid, operation, key_kind, name_upper, name_lower, age_value, phone_value,
    input  ready
  );
  modport sink (
    input  valid, operation, key_kind, name_upper, name_lower, age_value, phone_value,
    output ready
  );
endinterface

interface rtsd_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rtsd_pkg::STATUS_W-1:0]    status;
  logic [rtsd_pkg::INDEX_W-1:0]     match_index;
  logic [rtsd_pkg::NAME_HI_W-1:0]   found_name_upper;
  logic [rtsd_pkg::NAME_LO_W-1:0]   found_name_lower;
  logic [rtsd_pkg::AGE_W-1:0]       found_age;
  logic [rtsd_pkg::PHONE_W-1:0]     found_phone;
  logic [rtsd_pkg::COUNT_W-1:0]     record_count;

  modport source (
    output valid, status, match_index, found_name_upper, found_name_lower, found_age,
           found_phone, record_count,
    input  ready
  );
  modport sink (
    input  valid, status, match_index, found_name_upper, found_name_lower, found_age,
           found_phone, record_count,
    output ready
  );
endinterface

// File: src/rtsd_store.sv
module rtsd_store #(
  parameter int unsigned ENTRIES = rtsd_pkg::ENTRIES_DEF,
  parameter int unsigned ADDR_W  = 4
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  rtsd_pkg::record_t   wr_data_i,
  input  logic                rd_en_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output rtsd_pkg::record_t   rd_data_o
);

  rtsd_pkg::record_t mem_q [ENTRIES];
  rtsd_pkg::record_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/rtsd_match.sv
module rtsd_match #(
  parameter int unsigned NAME_BYTES = rtsd_pkg::NAME_BYTES_DEF
) (
  input  logic [rtsd_pkg::KIND_W-1:0] key_kind_i,
  input  rtsd_pkg::record_t           key_i,
  input  rtsd_pkg::record_t           entry_i,
  output logic                        hit_o
);

  logic [rtsd_pkg::NAME_W-1:0] key_name;
  logic [rtsd_pkg::NAME_W-1:0] entry_name;
  logic                        name_eq;

  assign key_name   = {key_i.name_upper, key_i.name_lower};
  assign entry_name = {entry_i.name_upper, entry_i.name_lower};

  // String compare: bytes after the first NUL in the stored name do not count
  always_comb begin
    logic seen_nul;
    logic [7:0] a;
    logic [7:0] b;
    name_eq  = 1'b1;
    seen_nul = 1'b0;
    for (int unsigned i = 0; i < NAME_BYTES; i++) begin
      a = entry_name[rtsd_pkg::NAME_W-1-8*i -: 8];
      b = key_name[rtsd_pkg::NAME_W-1-8*i -: 8];
      if (!seen_nul && (a != b)) begin
        name_eq = 1'b0;
      end
      seen_nul = seen_nul | (a == 8'd0);
    end
  end

  always_comb begin
    case (key_kind_i)
      rtsd_pkg::KEY_NAME:  hit_o = name_eq;
      rtsd_pkg::KEY_AGE:   hit_o = (entry_i.age == key_i.age);
      rtsd_pkg::KEY_PHONE: hit_o = (entry_i.phone == key_i.phone);
      default:             hit_o = 1'b0;
    endcase
  end

endmodule

// File: src/record_table_search_delete.sv
// Record table with insert, find-first and compacting delete. Records live in
// a single-port-read memory of ENTRIES rows; the sequencer walks it one row per
// cycle, feeding each row through one shared key comparator. A find stops at
// the first matching index k, or after the last row when nothing matches. A
// delete at index k scans k+1 rows and then moves the count-1-k later rows
// down one place, one per cycle. The rate is set by the one read port of the
// record memory. A new item is accepted only when the sequencer is idle; the
// result is held in an output register, so the next item may be accepted while
// a result still waits to be taken.
module record_table_search_delete #(
  parameter int unsigned ENTRIES    = rtsd_pkg::ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = rtsd_pkg::NAME_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtsd_req_if.sink    req_i,
  rtsd_rsp_if.source  rsp_o
);

  localparam int unsigned ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned EXT_W  = CNT_W + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                      state_q, state_d;
  logic [ADDR_W-1:0]               ptr_q, ptr_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [rtsd_pkg::OP_W-1:0]       op_q, op_d;
  logic [rtsd_pkg::KIND_W-1:0]     kind_q, kind_d;
  rtsd_pkg::record_t               key_q, key_d;
  logic [rtsd_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic [ADDR_W-1:0]               res_idx_q, res_idx_d;
  rtsd_pkg::record_t               res_rec_q, res_rec_d;

  logic                            out_valid_q, out_valid_d;
  logic                            out_load;
  logic [rtsd_pkg::STATUS_W-1:0]   out_status_q;
  logic [rtsd_pkg::INDEX_W-1:0]    out_idx_q;
  rtsd_pkg::record_t               out_rec_q;
  logic [rtsd_pkg::COUNT_W-1:0]    out_count_q;

  logic                            accept;
  logic                            hit;
  logic                            last_row;
  logic                            more_shift;
  rtsd_pkg::record_t               new_rec;

  logic                            wr_en;
  logic [ADDR_W-1:0]               wr_addr;
  rtsd_pkg::record_t               wr_data;
  logic                            rd_en;
  logic [ADDR_W-1:0]               rd_addr;
  rtsd_pkg::record_t               rd_data;

  rtsd_store #(
    .ENTRIES (ENTRIES),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rtsd_match #(
    .NAME_BYTES (NAME_BYTES)
  ) u_match (
    .key_kind_i (kind_q),
    .key_i      (key_q),
    .entry_i    (rd_data),
    .hit_o      (hit)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign new_rec.name_upper = req_i.name_upper;
  assign new_rec.name_lower = req_i.name_lower;
  assign new_rec.age        = req_i.age_value;
  assign new_rec.phone      = req_i.phone_value;

  assign last_row   = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);
  assign more_shift = ((EXT_W'(ptr_q) + EXT_W'(2)) < EXT_W'(count_q));

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    count_d      = count_q;
    op_d         = op_q;
    kind_d       = kind_q;
    key_d        = key_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_rec_d    = res_rec_q;
    wr_en        = 1'b0;
    wr_addr      = ptr_q;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = ADDR_W'(EXT_W'(ptr_q) + EXT_W'(1));
    out_load     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d         = req_i.operation;
          kind_d       = req_i.key_kind;
          key_d        = new_rec;
          res_idx_d    = '0;
          res_rec_d    = '0;
          res_status_d = rtsd_pkg::ST_NOT_FOUND;
          state_d      = S_FINISH;
          case (req_i.operation)
            rtsd_pkg::OP_INSERT: begin
              if (count_q >= CNT_W'(ENTRIES)) begin
                res_status_d = rtsd_pkg::ST_FULL;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = count_q[ADDR_W-1:0];
                wr_data      = new_rec;
                res_idx_d    = count_q[ADDR_W-1:0];
                res_rec_d    = new_rec;
                res_status_d = rtsd_pkg::ST_OK;
                count_d      = count_q + CNT_W'(1);
              end
            end
            rtsd_pkg::OP_DELETE, rtsd_pkg::OP_FIND: begin
              if (count_q == '0) begin
                res_status_d = rtsd_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              res_status_d = rtsd_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          res_status_d = rtsd_pkg::ST_OK;
          res_idx_d    = ptr_q;
          res_rec_d    = rd_data;
          state_d      = S_FINISH;
          if (op_q == rtsd_pkg::OP_DELETE) begin
            if (last_row) begin
              count_d = count_q - CNT_W'(1);
            end else begin
              // fetch the row after the victim to start compacting
              rd_en   = 1'b1;
              state_d = S_SHIFT;
            end
          end
        end else if (last_row) begin
          res_status_d = rtsd_pkg::ST_NOT_FOUND;
          state_d      = S_FINISH;
        end else begin
          rd_en = 1'b1;
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end

      S_SHIFT: begin
        // move row ptr+1 down into ptr
        wr_en   = 1'b1;
        wr_addr = ptr_q;
        wr_data = rd_data;
        if (more_shift) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(EXT_W'(ptr_q) + EXT_W'(2));
          ptr_d   = ptr_q + ADDR_W'(1);
        end else begin
          count_d = count_q - CNT_W'(1);
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    op_q         <= op_d;
    kind_q       <= kind_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_rec_q    <= res_rec_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= rtsd_pkg::INDEX_W'(res_idx_q);
      out_rec_q    <= res_rec_q;
      out_count_q  <= rtsd_pkg::COUNT_W'(count_q);
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.status           = out_status_q;
  assign rsp_o.match_index      = out_idx_q;
  assign rsp_o.found_name_upper = out_rec_q.name_upper;
  assign rsp_o.found_name_lower = out_rec_q.name_lower;
  assign rsp_o.found_age        = out_rec_q.age;
  assign rsp_o.found_phone      = out_rec_q.phone;
  assign rsp_o.record_count     = out_count_q;

endmodule
